@@ rtl/core/kic_pkg.sv @@
// ----------------------------------------------------------------------------
// kic_pkg: shared types and constants of the keypad calculator
// Phase codes, operator codes, channel payloads and the arithmetic unit
// command format.
// ----------------------------------------------------------------------------
package kic_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned DispW = 32;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_DIGIT1 = 3'd1;
	localparam logic [2:0] PH_OP1    = 3'd2;
	localparam logic [2:0] PH_OPER   = 3'd3;
	localparam logic [2:0] PH_DIGIT2 = 3'd4;
	localparam logic [2:0] PH_OP2    = 3'd5;
	localparam logic [2:0] PH_EQUAL  = 3'd6;
	localparam logic [2:0] PH_ERROR  = 3'd7;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF  = 2'd1;
	localparam logic [1:0] ERR_DIVZ = 2'd2;

	localparam logic [7:0] KEY_0     = 8'd48;
	localparam logic [7:0] KEY_9     = 8'd57;
	localparam logic [7:0] KEY_MUL   = 8'd42;
	localparam logic [7:0] KEY_ADD   = 8'd43;
	localparam logic [7:0] KEY_SUB   = 8'd45;
	localparam logic [7:0] KEY_DIV   = 8'd47;
	localparam logic [7:0] KEY_CLR   = 8'd99;
	localparam logic [7:0] KEY_EQUAL = 8'd61;

	localparam logic [63:0] LIMIT_POS = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] LIMIT_NEG = 64'hFFFF_FFFF_8000_0001;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_cmd_t;

	typedef struct packed {
		logic       key_valid;
		logic [7:0] key_code;
	} key_t;

	typedef struct packed {
		logic signed [31:0] display_value;
		logic [2:0]         mode_code;
		logic [1:0]         error_kind;
	} res_t;

endpackage

@@ rtl/core/kic_if.sv @@
// ----------------------------------------------------------------------------
// kic_if: valid/ready channel
// Carries one payload of type parameter PAYLOAD_T between source and sink.
// ----------------------------------------------------------------------------
interface kic_if #(parameter type PAYLOAD_T = logic) ();
	logic     valid;
	logic     ready;
	PAYLOAD_T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/kic_alu.sv @@
// ----------------------------------------------------------------------------
// kic_alu: shared multi-cycle arithmetic unit
// Add and subtract are computed as the command is taken; multiply by shift-add and signed divide by
// restoring shift-subtract, one bit per cycle.
// ----------------------------------------------------------------------------
module kic_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  kic_pkg::alu_cmd_t          cmd,
	output logic                       done,
	output logic [kic_pkg::DataW-1:0]  result
);
	typedef enum logic [1:0] {IDLE, MUL, DIV, FIN} alu_state_t;

	alu_state_t                 state_q;
	logic [kic_pkg::DataW-1:0]  acc_q, mc_q, mp_q, rem_q;
	logic [6:0]                 cnt_q;
	logic                       neg_q;
	logic [kic_pkg::DataW:0]    trial;
	logic [kic_pkg::DataW-1:0]  rem_sh;

	assign rem_sh = {rem_q[kic_pkg::DataW-2:0], mp_q[kic_pkg::DataW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, mc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						cnt_q <= '0;
						case (cmd.op)
							kic_pkg::OP_ADD: begin
								result  <= cmd.a + cmd.b;
								state_q <= FIN;
							end
							kic_pkg::OP_SUB: begin
								result  <= cmd.a - cmd.b;
								state_q <= FIN;
							end
							kic_pkg::OP_MUL: begin
								acc_q   <= '0;
								mc_q    <= cmd.a;
								mp_q    <= cmd.b;
								state_q <= MUL;
							end
							default: begin
								// magnitudes; quotient builds in mp_q
								mp_q    <= cmd.a[63] ? -cmd.a : cmd.a;
								mc_q    <= cmd.b[63] ? -cmd.b : cmd.b;
								rem_q   <= '0;
								neg_q   <= cmd.a[63] ^ cmd.b[63];
								state_q <= DIV;
							end
						endcase
					end
				end
				MUL: begin
					if (mp_q[0])
						acc_q <= acc_q + mc_q;
					mc_q  <= mc_q << 1;
					mp_q  <= mp_q >> 1;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(kic_pkg::DataW - 1)) begin
						result  <= mp_q[0] ? acc_q + mc_q : acc_q;
						state_q <= FIN;
					end
				end
				DIV: begin
					if (!trial[kic_pkg::DataW]) begin
						rem_q <= trial[kic_pkg::DataW-1:0];
						mp_q  <= {mp_q[kic_pkg::DataW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						mp_q  <= {mp_q[kic_pkg::DataW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(kic_pkg::DataW - 1))
						state_q <= FIN;
				end
				FIN: begin
					done    <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (state_q == DIV && cnt_q == 7'(kic_pkg::DataW - 1))
				result <= neg_q ? -{mp_q[kic_pkg::DataW-2:0], ~trial[kic_pkg::DataW]}
					: {mp_q[kic_pkg::DataW-2:0], ~trial[kic_pkg::DataW]};
		end
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_done_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == FIN) else $error("done without finish");
	a_busy_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL |=> state_q == MUL || state_q == FIN) else $error("mul left early");
`endif
endmodule

@@ rtl/core/keypad_integer_calculator.sv @@
// ----------------------------------------------------------------------------
// keypad_integer_calculator: keypad-driven four-function calculator
// Eight-phase sequencer over one shared add/sub/multiply/divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one tick: key_valid and key_code. Every tick, key or not,
//   produces exactly one transfer on res_out: display_value, mode_code (the
//   phase that ran) and error_kind.
//   A tick is taken only when the block is idle (key_in.ready high). Phases
//   that need no arithmetic go straight to the output register; a divide by
//   zero resolves in the evaluate step with no unit pass; add, subtract, the
//   digit step, multiply and divide each take one pass through the unit, and
//   multiply and divide, which are bit-serial over 64 bits, set the worst
//   case. The next tick can be taken in the cycle after the result transfer.
//   The result sits in an output register; while the receiver stalls, hold
//   it and take no new tick, since the state update already happened.
//   Reset puts the machine in the start phase with all operands zero and the
//   output register empty.
// ----------------------------------------------------------------------------
module keypad_integer_calculator (
	input  logic clk,
	input  logic arst_n,
	kic_if.sink   key_in,
	kic_if.source res_out
);
	typedef enum logic [2:0] {S_IDLE, S_DIG, S_EVAL, S_EQ, S_OUT} seq_t;

	seq_t        seq_q;
	logic [2:0]  phase_q;
	logic [63:0] first_q, second_q, answer_q;
	logic [1:0]  pend_q, next_q;
	logic        sec_q, divz_q;
	logic [3:0]  digit_q;
	logic [7:0]  key_q;
	logic        kv_q;

	logic                  alu_start, alu_done;
	kic_pkg::alu_cmd_t     alu_cmd;
	logic [63:0]           alu_res;

	kic_alu u_alu (.clk, .arst_n, .start(alu_start), .cmd(alu_cmd),
		.done(alu_done), .result(alu_res));

	function automatic logic sgt(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) > $signed(b);
	endfunction
	function automatic logic oor(input logic [63:0] v);
		return sgt(v, kic_pkg::LIMIT_POS) || sgt(kic_pkg::LIMIT_NEG, v);
	endfunction

	logic       is_dig, is_op, is_clr, is_eq;
	logic [1:0] opc;
	always_comb begin
		is_dig = key_in.data.key_code >= kic_pkg::KEY_0 && key_in.data.key_code <= kic_pkg::KEY_9;
		is_clr = key_in.data.key_code == kic_pkg::KEY_CLR;
		is_eq  = key_in.data.key_code == kic_pkg::KEY_EQUAL;
		is_op  = 1'b1;
		case (key_in.data.key_code)
			kic_pkg::KEY_ADD: opc = kic_pkg::OP_ADD;
			kic_pkg::KEY_SUB: opc = kic_pkg::OP_SUB;
			kic_pkg::KEY_MUL: opc = kic_pkg::OP_MUL;
			kic_pkg::KEY_DIV: opc = kic_pkg::OP_DIV;
			default: begin
				opc   = kic_pkg::OP_ADD;
				is_op = 1'b0;
			end
		endcase
	end

	logic kdig, kclr;
	assign kdig = kv_q && key_q >= kic_pkg::KEY_0 && key_q <= kic_pkg::KEY_9;
	assign kclr = kv_q && key_q == kic_pkg::KEY_CLR;

	assign key_in.ready = seq_q == S_IDLE;
	assign res_out.valid = seq_q == S_OUT;

	// digit step: operand*10 = (x<<3)+(x<<1) in the unit, then + digit in S_DIG
	always_comb begin
		alu_start = 1'b0;
		alu_cmd   = '0;
		if (seq_q == S_IDLE && key_in.valid) begin
			if (phase_q == kic_pkg::PH_DIGIT1) begin
				alu_start = 1'b1;
				alu_cmd   = '{kic_pkg::OP_ADD, first_q << 3, first_q << 1};
			end else if (phase_q == kic_pkg::PH_DIGIT2) begin
				alu_start = 1'b1;
				alu_cmd   = '{kic_pkg::OP_ADD, second_q << 3, second_q << 1};
			end else if ((phase_q == kic_pkg::PH_OPER || phase_q == kic_pkg::PH_EQUAL)
				&& sec_q && !(pend_q == kic_pkg::OP_DIV && second_q == '0)) begin
				alu_start = 1'b1;
				alu_cmd   = '{pend_q, first_q, second_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= S_IDLE;
			phase_q <= kic_pkg::PH_START;
			first_q <= '0;
			second_q <= '0;
			answer_q <= '0;
			pend_q  <= '0;
			next_q  <= '0;
			sec_q   <= 1'b0;
			divz_q  <= 1'b0;
			digit_q <= '0;
			kv_q    <= 1'b0;
			key_q   <= '0;
		end else begin
			case (seq_q)
				S_IDLE: begin
					if (key_in.valid) begin
						kv_q  <= key_in.data.key_valid;
						key_q <= key_in.data.key_code;
						res_out.data.mode_code  <= phase_q;
						res_out.data.error_kind <= kic_pkg::ERR_NONE;
						seq_q <= S_OUT;
						case (phase_q)
							kic_pkg::PH_START: begin
								sec_q <= 1'b0;
								answer_q <= '0;
								divz_q <= 1'b0;
								first_q <= '0;
								second_q <= '0;
								if (key_in.data.key_valid && is_dig) begin
									digit_q <= 4'(key_in.data.key_code - kic_pkg::KEY_0);
									phase_q <= kic_pkg::PH_DIGIT1;
								end
								res_out.data.display_value <= '0;
							end
							kic_pkg::PH_DIGIT1, kic_pkg::PH_DIGIT2: seq_q <= S_DIG;
							kic_pkg::PH_OP1: begin
								if (sgt(first_q, kic_pkg::LIMIT_POS))
									phase_q <= kic_pkg::PH_ERROR;
								if (key_in.data.key_valid) begin
									if (is_dig) begin
										digit_q <= 4'(key_in.data.key_code - kic_pkg::KEY_0);
										phase_q <= kic_pkg::PH_DIGIT1;
									end
									if (is_op) begin
										pend_q  <= opc;
										phase_q <= kic_pkg::PH_OPER;
									end
									if (is_clr) phase_q <= kic_pkg::PH_START;
									if (is_eq)  phase_q <= kic_pkg::PH_EQUAL;
								end
								res_out.data.display_value <= first_q[31:0];
							end
							kic_pkg::PH_OPER: begin
								// evaluate, or resolve a divide by zero, in S_EVAL
								if (sec_q) seq_q <= S_EVAL;
								else begin
									if (key_in.data.key_valid && is_dig) begin
										digit_q <= 4'(key_in.data.key_code - kic_pkg::KEY_0);
										phase_q <= kic_pkg::PH_DIGIT2;
									end
									if (key_in.data.key_valid && is_clr)
										phase_q <= kic_pkg::PH_START;
									res_out.data.display_value <= first_q[31:0];
								end
							end
							kic_pkg::PH_OP2: begin
								if (sgt(second_q, kic_pkg::LIMIT_POS) || oor(first_q))
									phase_q <= kic_pkg::PH_ERROR;
								if (key_in.data.key_valid) begin
									if (is_dig) begin
										digit_q <= 4'(key_in.data.key_code - kic_pkg::KEY_0);
										phase_q <= kic_pkg::PH_DIGIT2;
									end
									if (is_op) begin
										next_q  <= opc;
										phase_q <= kic_pkg::PH_OPER;
									end
									if (is_clr) phase_q <= kic_pkg::PH_START;
									if (is_eq)  phase_q <= kic_pkg::PH_EQUAL;
								end
								res_out.data.display_value <= second_q[31:0];
							end
							kic_pkg::PH_EQUAL: begin
								if (sec_q) seq_q <= S_EQ;
								else begin
									answer_q <= first_q;
									res_out.data.display_value <= first_q[31:0];
									if (key_in.data.key_valid && is_clr)
										phase_q <= kic_pkg::PH_START;
								end
							end
							default: begin
								res_out.data.error_kind <= divz_q ? kic_pkg::ERR_DIVZ
									: kic_pkg::ERR_OVF;
								res_out.data.display_value <= '0;
								if (key_in.data.key_valid && is_clr)
									phase_q <= kic_pkg::PH_START;
							end
						endcase
					end
				end
				S_DIG: begin
					if (alu_done) begin
						// add the digit; 10x + d fits a plain adder
						if (phase_q == kic_pkg::PH_DIGIT1) begin
							first_q  <= alu_res + 64'(digit_q);
							answer_q <= alu_res + 64'(digit_q);
							phase_q  <= kic_pkg::PH_OP1;
						end else begin
							sec_q    <= 1'b1;
							second_q <= alu_res + 64'(digit_q);
							phase_q  <= kic_pkg::PH_OP2;
						end
						res_out.data.display_value <= alu_res[31:0] + 32'(digit_q);
						seq_q <= S_OUT;
					end
				end
				S_EVAL, S_EQ: begin
					// divide by zero needs no unit pass
					if (alu_done || (pend_q == kic_pkg::OP_DIV && second_q == '0)) begin
						logic [63:0] ans;
						logic        dz;
						dz  = !alu_done;
						ans = dz ? answer_q : alu_res;
						answer_q <= ans;
						if (dz) divz_q <= 1'b1;
						if (dz || oor(ans)) phase_q <= kic_pkg::PH_ERROR;
						if (seq_q == S_EVAL) begin
							pend_q   <= next_q;
							first_q  <= ans;
							second_q <= '0;
							sec_q    <= 1'b0;
							res_out.data.display_value <= ans[31:0];
							if (kdig) begin
								digit_q <= 4'(key_q - kic_pkg::KEY_0);
								phase_q <= kic_pkg::PH_DIGIT2;
							end
						end else
							res_out.data.display_value <= ans[31:0];
						if (kclr) phase_q <= kic_pkg::PH_START;
						seq_q <= S_OUT;
					end
				end
				S_OUT: if (res_out.ready) seq_q <= S_IDLE;
				default: seq_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_err_only_in_error: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.data.error_kind != kic_pkg::ERR_NONE
		|-> res_out.data.mode_code == kic_pkg::PH_ERROR) else $error("error kind leak");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid) else $error("result dropped");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != S_IDLE |-> !key_in.ready) else $error("ready while busy");
`endif
endmodule
